// ===== rtl/core/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared constants and types of the divisor-sum unit.
// ----------------------------------------------------------------------------
package dsf_pkg;

   // Width of the input value and size of the prime-flag table.
   localparam int N_BITS      = 26;
   localparam int PRIME_LIMIT = 8192;

   // Result width: sigma(n) is kept modulo 2^SUM_W.
   localparam int SUM_W = 29;

   // Prime-table index width, and a candidate counter that can also hold PRIME_LIMIT.
   localparam int P_BITS = $clog2(PRIME_LIMIT);
   localparam int PC_W   = P_BITS + 1;

   // Square of a candidate, and the width used when comparing it with the value.
   localparam int PSQ_W = 2 * PC_W;
   localparam int CMP_W = (PSQ_W > N_BITS) ? PSQ_W : N_BITS;

   // Divider: DIV_STEPS quotient bits per cycle.
   localparam int DIV_STEPS  = 4;
   localparam int DIV_CYCLES = (N_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W      = DIV_CYCLES * DIV_STEPS;
   localparam int DCNT_W     = $clog2(DIV_CYCLES);

   // Stream data widths, padded to whole bytes.
   localparam int REQ_DATA_W = ((N_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SUM_W + 7) / 8) * 8;

   typedef struct packed {
      logic              start;
      logic [N_BITS-1:0] dividend;
      logic [P_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic              rem_zero;
      logic [N_BITS-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic ready;
      logic flag;
   } flags_rsp_type;

endpackage

// ===== rtl/core/dsf_div.sv =====
// ----------------------------------------------------------------------------
// dsf_div
// Iterative restoring divider: value by prime candidate, DIV_STEPS bits a cycle.
// ----------------------------------------------------------------------------
module dsf_div import dsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [P_BITS-1:0] rem_ff, rem_in;
   logic [P_BITS-1:0] dvs_ff, dvs_in;
   logic [P_BITS:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = '0;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = DIV_W'(div_req.dividend);
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         // The dividend shifts out of the top of quo while quotient bits enter below.
         for (int k = 0; k < DIV_STEPS; k++) begin
            trial  = {rem_in, quo_in[DIV_W-1]};
            quo_in = {quo_in[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_ff}) begin
               trial     = trial - {1'b0, dvs_ff};
               quo_in[0] = 1'b1;
            end
            rem_in = trial[P_BITS-1:0];
         end
         if (cnt_ff == DCNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.rem_zero = (rem_ff == '0);
   assign div_rsp.quotient = quo_ff[N_BITS-1:0];

endmodule

// ===== rtl/core/dsf_flags.sv =====
// ----------------------------------------------------------------------------
// dsf_flags
// Prime-flag memory with the sieve sequencer that fills it after reset.
// ----------------------------------------------------------------------------
module dsf_flags import dsf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [P_BITS-1:0] rd_addr,
   output flags_rsp_type     flags_rsp
);

   typedef enum logic [4:0] {
      SV_FILL  = 5'b00001,
      SV_READ  = 5'b00010,
      SV_CHECK = 5'b00100,
      SV_MARK  = 5'b01000,
      SV_DONE  = 5'b10000
   } sieve_state_type;

   sieve_state_type   state_ff, state_in;
   logic [P_BITS-1:0] addr_ff, addr_in;
   logic [PC_W-1:0]   base_ff, base_in;
   logic [PC_W-1:0]   mult_ff, mult_in;
   logic [PC_W-1:0]   mult_next;
   logic [PSQ_W-1:0]  base_sq;

   logic              flag_mem [PRIME_LIMIT];
   logic              rd_flag_ff;
   logic              wr_en;
   logic [P_BITS-1:0] wr_addr;
   logic              wr_data;
   logic [P_BITS-1:0] mem_raddr;

   assign base_sq   = base_ff * base_ff;
   assign mult_next = mult_ff + base_ff;

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      base_in   = base_ff;
      mult_in   = mult_ff;
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = 1'b0;
      mem_raddr = rd_addr;
      case (state_ff)
         SV_FILL: begin
            // Zero and one are not prime; everything else starts as a candidate.
            wr_en   = 1'b1;
            wr_data = (addr_ff > P_BITS'(1));
            if (addr_ff == P_BITS'(PRIME_LIMIT - 1)) begin
               base_in  = PC_W'(2);
               state_in = SV_READ;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         SV_READ: begin
            if (base_sq >= PSQ_W'(PRIME_LIMIT)) begin
               state_in = SV_DONE;
            end else begin
               mem_raddr = base_ff[P_BITS-1:0];
               state_in  = SV_CHECK;
            end
         end
         SV_CHECK: begin
            if (rd_flag_ff) begin
               mult_in  = base_sq[PC_W-1:0];
               state_in = SV_MARK;
            end else begin
               base_in  = base_ff + 1'b1;
               state_in = SV_READ;
            end
         end
         SV_MARK: begin
            wr_en   = 1'b1;
            wr_addr = mult_ff[P_BITS-1:0];
            wr_data = 1'b0;
            if (mult_next >= PC_W'(PRIME_LIMIT)) begin
               base_in  = base_ff + 1'b1;
               state_in = SV_READ;
            end else begin
               mult_in = mult_next;
            end
         end
         SV_DONE: begin
            mem_raddr = rd_addr;
         end
         default: begin
            state_in = SV_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SV_FILL;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      mult_ff <= mult_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         flag_mem[wr_addr] <= wr_data;
      end
      rd_flag_ff <= flag_mem[mem_raddr];
   end

   assign flags_rsp.ready = (state_ff == SV_DONE);
   assign flags_rsp.flag  = rd_flag_ff;

endmodule

// ===== rtl/core/divisor_sum_by_factorization.sv =====
// ----------------------------------------------------------------------------
// divisor_sum_by_factorization
// Sum of divisors sigma(n) by trial division over a sieved prime table.
// ----------------------------------------------------------------------------
// After reset the block sieves its prime-flag memory and holds req_tready low
// until that is finished. Items are then handled one at a time. For each
// candidate p, while p*p does not exceed the remaining value, its flag is read;
// each prime tried is handed to the divider, which works on a 26-bit value at
// four quotient bits a cycle, and each factor found repeats the division on the
// reduced value. A large prime input thus takes far longer than a small or
// smooth value. An input of zero returns zero, an input of one returns one, and
// a leftover factor above the table is treated as prime.
// ----------------------------------------------------------------------------
module divisor_sum_by_factorization import dsf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [25:0] value_in, zeros above
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [28:0] divisor_sum, zeros above
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_TEST = 8'b00000010,
      ST_DIV  = 8'b00000100,
      ST_POW  = 8'b00001000,
      ST_SER  = 8'b00010000,
      ST_TOT  = 8'b00100000,
      ST_FIN  = 8'b01000000,
      ST_OUT  = 8'b10000000
   } state_type;

   state_type          state_ff, state_in;
   logic [N_BITS-1:0]  n_ff, n_in;
   logic [PC_W-1:0]    p_ff, p_in;
   logic [PSQ_W-1:0]   psq_ff, psq_in;
   logic [SUM_W-1:0]   power_ff, power_in;
   logic [SUM_W-1:0]   series_ff, series_in;
   logic [SUM_W-1:0]   total_ff, total_in;

   logic [N_BITS-1:0]  value;
   logic [N_BITS:0]    n_plus;
   logic               keep_going;
   logic [SUM_W-1:0]   mul_op;
   logic [2*SUM_W-1:0] tot_prod;
   logic [SUM_W+PC_W-1:0] pow_prod;

   div_req_type        div_req;
   div_rsp_type        div_rsp;
   flags_rsp_type      flags_rsp;

   dsf_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (p_in[P_BITS-1:0]),
      .flags_rsp (flags_rsp)
   );

   dsf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign value      = req_tdata[N_BITS-1:0];
   assign n_plus     = {1'b0, n_ff} + 1'b1;
   assign keep_going = (p_ff < PC_W'(PRIME_LIMIT)) && (CMP_W'(psq_ff) <= CMP_W'(n_ff));
   assign mul_op     = (state_ff == ST_FIN) ? SUM_W'(n_plus) : series_ff;
   assign tot_prod   = total_ff * mul_op;
   assign pow_prod   = power_ff * p_ff;

   assign req_tready = (state_ff == ST_IDLE) && flags_rsp.ready;

   always_comb begin
      state_in         = state_ff;
      n_in             = n_ff;
      p_in             = p_ff;
      psq_in           = psq_ff;
      power_in         = power_ff;
      series_in        = series_ff;
      total_in         = total_ff;
      div_req.start    = 1'b0;
      div_req.dividend = n_ff;
      div_req.divisor  = p_ff[P_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               n_in     = value;
               // Zero has no divisor sum and leaves the product at zero.
               total_in = {{(SUM_W-1){1'b0}}, (value != '0)};
               p_in     = PC_W'(2);
               psq_in   = PSQ_W'(4);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (!keep_going) begin
               state_in = ST_FIN;
            end else if (flags_rsp.flag) begin
               power_in      = SUM_W'(1);
               series_in     = SUM_W'(1);
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               p_in   = p_ff + 1'b1;
               psq_in = psq_ff + PSQ_W'({p_ff, 1'b1});
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.rem_zero) begin
                  n_in     = div_rsp.quotient;
                  state_in = ST_POW;
               end else begin
                  state_in = ST_TOT;
               end
            end
         end
         ST_POW: begin
            power_in = pow_prod[SUM_W-1:0];
            state_in = ST_SER;
         end
         ST_SER: begin
            // Add the new power and try the same prime again on the reduced value.
            series_in     = series_ff + power_ff;
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_TOT: begin
            total_in = tot_prod[SUM_W-1:0];
            p_in     = p_ff + 1'b1;
            psq_in   = psq_ff + PSQ_W'({p_ff, 1'b1});
            state_in = ST_TEST;
         end
         ST_FIN: begin
            if (n_ff > N_BITS'(1)) begin
               total_in = tot_prod[SUM_W-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      p_ff      <= p_in;
      psq_ff    <= psq_in;
      power_ff  <= power_in;
      series_ff <= series_in;
      total_ff  <= total_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = RSP_DATA_W'(total_ff);

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result transfer is pending");

   a_sieve_first: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> flags_rsp.ready)
      else $error("input taken before the prime table is built");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the division state");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_FIN))
      else $error("result presented without the final step");
`endif

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the divisor-sum unit.
// ----------------------------------------------------------------------------
// Values go in on the request stream and each divisor sum comes back on the
// response stream. The bench keeps its own sieve and factorization to predict
// every sum and compares each response with the oldest prediction. A directed
// set covers zero, one, prime powers, primes at and above the table bound, and
// the largest inputs. A random set then mixes sizes, weighted toward small
// values because large primes take by far the longest. Both sides stall in
// random bursts, except in the final part of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import dsf_pkg::*;

   // One long quiet stretch is the post-reset sieve.
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int TAIL_CYCLES    = 64;
   localparam int MAX_REPORTS    = 10;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [25:0] value_in, zeros above
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [28:0] divisor_sum, zeros above

   bit                    is_prime [PRIME_LIMIT];
   logic [SUM_W-1:0]      pending_sums [$];
   bit                    idle_on;
   int unsigned           stall_left;
   int unsigned           quiet_cycles;
   int unsigned           mismatches;
   int unsigned           values_sent;
   int unsigned           sums_checked;
   int unsigned           full_range_sent;

   divisor_sum_by_factorization uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   task automatic build_prime_table();
      int i;
      int j;
      for (i = 0; i < PRIME_LIMIT; i++) is_prime[i] = 1'b1;
      is_prime[0] = 1'b0;
      is_prime[1] = 1'b0;
      for (i = 2; i * i < PRIME_LIMIT; i++) begin
         if (is_prime[i]) begin
            for (j = i * i; j < PRIME_LIMIT; j += i) is_prime[j] = 1'b0;
         end
      end
   endtask

   // Trial division over the table; whatever remains above the last tried
   // prime is itself prime and contributes (rest + 1).
   function automatic logic [SUM_W-1:0] sigma_of(input logic [N_BITS-1:0] value);
      longint unsigned rest;
      longint unsigned total;
      longint unsigned power;
      longint unsigned series;
      longint unsigned p;
      rest = 64'(value);
      if (rest == 0) return '0;
      total = 1;
      for (p = 2; p < PRIME_LIMIT && p * p <= rest; p++) begin
         if (!is_prime[p]) continue;
         power  = 1;
         series = 1;
         while (rest % p == 0) begin
            rest   = rest / p;
            power  = power * p;
            series = series + power;
         end
         total = total * series;
      end
      if (rest > 1) total = total * (rest + 1);
      return total[SUM_W-1:0];
   endfunction

   // Product of up to 14 primes from 2 to 61, the product kept below the input range.
   function automatic logic [N_BITS-1:0] smooth_value();
      longint unsigned product;
      int unsigned     p;
      product = 1;
      repeat ($urandom_range(1, 14)) begin
         do p = $urandom_range(2, 61); while (!is_prime[p]);
         if (product * p < (64'd1 << N_BITS)) product = product * p;
      end
      return product[N_BITS-1:0];
   endfunction

   function automatic logic [N_BITS-1:0] random_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 1)       return '0;
      else if (roll < 55) return N_BITS'($urandom_range(1, 16'hFFFF));
      else if (roll < 80) return N_BITS'($urandom_range(1, 20'hFFFFF));
      else if (roll < 92) return smooth_value();
      else                return N_BITS'($urandom_range(1, (1 << N_BITS) - 1));
   endfunction

   // Called at a clock edge; returns at the edge where the transfer happened,
   // with req_tvalid still high so that the next call can follow directly.
   task automatic send_value(input logic [N_BITS-1:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - N_BITS){1'b0}}, value};
      do @(posedge clock); while (!req_tready);
      pending_sums.insert(pending_sums.size(), sigma_of(value));
      values_sent++;
      if (value >= (1 << 20)) full_range_sent++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_sums.size() != 0);
   endtask

   task automatic test_corner_values();
      int unsigned corner_values [20] = '{
         0, 1, 2, 3, 4, 9, 8191, 8192, 8209, 16382,
         720720, 9699690, 33554432, 43046721, 66994189, 67092481,
         67108859, 67108863, 26'h2AAAAAA, 26'h1555555
      };
      foreach (corner_values[i]) send_value(N_BITS'(corner_values[i]));
      // Let the block go fully idle once before the random part.
      wait_for_drain();
   endtask

   task automatic test_random_mixed(input int count);
      repeat (count) send_value(random_value());
   endtask

   task automatic test_smooth_values(input int count);
      repeat (count) send_value(smooth_value());
      wait_for_drain();
   endtask

   task automatic test_without_stalls(input int count);
      idle_on <= 1'b0;
      repeat (count) send_value(random_value());
   endtask

   // Receiver side: random stall bursts while idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb: unexpected transfer, divisor_sum=%0d", rsp_tdata[SUM_W-1:0]);
         end else begin
            logic [SUM_W-1:0] wanted;
            wanted = pending_sums.pop_front();
            sums_checked++;
            if (rsp_tdata[SUM_W-1:0] !== wanted) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("tb: divisor_sum mismatch, expected %0d, got %0d",
                           wanted, rsp_tdata[SUM_W-1:0]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired with %0d sums outstanding", pending_sums.size());
            $display("tb: errors");
            $finish;
         end
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      rsp_tready      = 1'b0;
      idle_on         = 1'b1;
      stall_left      = 0;
      quiet_cycles    = 0;
      mismatches      = 0;
      values_sent     = 0;
      sums_checked    = 0;
      full_range_sent = 0;
      build_prime_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_corner_values();
      test_random_mixed(200);
      test_smooth_values(40);
      test_without_stalls(60);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("tb: %0d values sent, %0d sums checked, %0d of them at or above 2^20",
               values_sent, sums_checked, full_range_sent);
      $display("tb: covered zero, one, primes and prime powers near the table bound,");
      $display("tb: smooth values and random sizes, with stalls on both streams");
      if (mismatches == 0 && pending_sums.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/dsf_pkg.sv
rtl/core/dsf_div.sv
rtl/core/dsf_flags.sv
rtl/core/divisor_sum_by_factorization.sv
bench/tb.sv
